FILE: hw/rtl/stbs_pkg.sv
// Package for the sorted table binary search block.
// Holds the table size, derived widths, command codes, controller states
// and the command and status structs shared by controller and datapath.
package stbs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int VALUE_W     = 32;
    localparam int ENTRY_IDX_W = 4;
    localparam int POS_W       = 4;

    localparam int INDEX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W   = COUNT_W + 1;
    localparam int CMP_W   = (COUNT_W > ENTRY_IDX_W) ? COUNT_W : ENTRY_IDX_W;
    localparam int MID0    = (TABLE_DEPTH - 1) / 2;

    typedef logic [INDEX_W-1:0]     t_index;
    typedef logic [COUNT_W-1:0]     t_count;
    typedef logic [SUM_W-1:0]       t_sum;
    typedef logic [CMP_W-1:0]       t_cmp;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic tbl_write;
        logic load_search;
        logic probe_step;
        logic load_out_probe;
        logic load_out_held;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic probe_done;
    } t_dp_status;

endpackage

FILE: hw/rtl/stbs_if.sv
// Valid/ready channel interfaces for the binary search block.
// Depends on stbs_pkg for payload types.
interface stbs_in_if;
    logic                valid;
    logic                ready;
    logic                command;
    logic [3:0]          entry_index;
    stbs_pkg::t_value    entry_value;
    stbs_pkg::t_value    search_key;

    modport source (output valid, output command, output entry_index,
                    output entry_value, output search_key, input ready);
    modport sink   (input valid, input command, input entry_index,
                    input entry_value, input search_key, output ready);
endinterface

interface stbs_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [3:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

FILE: hw/rtl/stbs_ctrl.sv
// Controller state machine for the binary search block.
// Depends on stbs_pkg; drives the datapath through t_dp_cmd.
module stbs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_command,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    input  stbs_pkg::t_dp_status  i_status,
    output stbs_pkg::t_dp_cmd     o_cmd
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stbs_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            stbs_pkg::ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = stbs_pkg::ST_IDLE;
                end
            end
            stbs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_command == stbs_pkg::CMD_SEARCH) begin
                        o_cmd.load_search = 1'b1;
                        n_state           = stbs_pkg::ST_PROBE;
                    end else begin
                        o_cmd.tbl_write = 1'b1;
                    end
                end
            end
            stbs_pkg::ST_PROBE: begin
                o_cmd.probe_step = 1'b1;
                if (i_status.probe_done) begin
                    if (w_out_free) begin
                        o_cmd.load_out_probe = 1'b1;
                        n_out_valid          = 1'b1;
                        n_state              = stbs_pkg::ST_IDLE;
                    end else begin
                        n_state = stbs_pkg::ST_HOLD;
                    end
                end
            end
            stbs_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    o_cmd.load_out_held = 1'b1;
                    n_out_valid         = 1'b1;
                    n_state             = stbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/stbs_datapath.sv
// Datapath of the binary search block: table memory, search bounds,
// probe compare and result register. Depends on stbs_pkg.
module stbs_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stbs_pkg::t_dp_cmd     i_cmd,
    output stbs_pkg::t_dp_status  o_status,
    input  logic [3:0]            i_entry_index,
    input  stbs_pkg::t_value      i_entry_value,
    input  stbs_pkg::t_value      i_search_key,
    output logic                  o_found,
    output logic [3:0]            o_position
);

    stbs_pkg::t_value r_mem [stbs_pkg::TABLE_DEPTH];
    stbs_pkg::t_value r_rd_data;
    stbs_pkg::t_value r_key;
    stbs_pkg::t_index r_clr_addr;
    stbs_pkg::t_index r_mid;
    stbs_pkg::t_count r_lo;
    stbs_pkg::t_count r_hi;
    stbs_pkg::t_count n_lo;
    stbs_pkg::t_count n_hi;
    stbs_pkg::t_sum   w_sum;
    stbs_pkg::t_index n_mid;
    logic             r_found;
    stbs_pkg::t_pos   r_pos;
    logic             w_hit;
    logic             w_done;
    logic             w_in_range;
    logic             w_we;
    stbs_pkg::t_index w_wr_addr;
    stbs_pkg::t_value w_wr_data;
    logic             w_rd_en;
    stbs_pkg::t_index w_rd_addr;

    assign w_in_range = stbs_pkg::t_cmp'(i_entry_index)
                        < stbs_pkg::t_cmp'(stbs_pkg::TABLE_DEPTH);
    assign w_we       = i_cmd.clear_wr || (i_cmd.tbl_write && w_in_range);
    assign w_wr_addr  = i_cmd.clear_wr ? r_clr_addr : stbs_pkg::t_index'(i_entry_index);
    assign w_wr_data  = i_cmd.clear_wr ? '0 : i_entry_value;

    assign w_hit = (r_rd_data == r_key);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (r_rd_data < r_key) begin
            n_lo = stbs_pkg::t_count'(r_mid) + stbs_pkg::t_count'(1);
        end else begin
            n_hi = stbs_pkg::t_count'(r_mid);
        end
    end

    assign w_done = w_hit || !(n_lo < n_hi);
    assign w_sum  = stbs_pkg::t_sum'(n_lo) + stbs_pkg::t_sum'(n_hi) - stbs_pkg::t_sum'(1);
    assign n_mid  = stbs_pkg::t_index'(w_sum >> 1);

    assign w_rd_en   = i_cmd.load_search || (i_cmd.probe_step && !w_done);
    assign w_rd_addr = i_cmd.load_search ? stbs_pkg::t_index'(stbs_pkg::MID0) : n_mid;

    assign o_status.clear_last =
        (r_clr_addr == stbs_pkg::t_index'(stbs_pkg::TABLE_DEPTH - 1));
    assign o_status.probe_done = w_done;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_mid     <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + stbs_pkg::t_index'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_search) begin
            r_key <= i_search_key;
            r_lo  <= '0;
            r_hi  <= stbs_pkg::t_count'(stbs_pkg::TABLE_DEPTH);
        end else if (i_cmd.probe_step) begin
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_found <= w_hit;
            r_pos   <= w_hit ? stbs_pkg::t_pos'(r_mid) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out_probe) begin
            o_found    <= w_hit;
            o_position <= w_hit ? stbs_pkg::t_pos'(r_mid) : '0;
        end else if (i_cmd.load_out_held) begin
            o_found    <= r_found;
            o_position <= r_pos;
        end
    end

endmodule

FILE: hw/rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_if, stbs_ctrl and stbs_datapath.
//
// Usage: items arrive on i_cmd. A write item (command 0) stores entry_value
// at entry_index in a 16-entry table and gives no result; an index beyond
// the table is ignored. A search item (command 1) runs a binary search for
// search_key and gives one result item on o_res with found and position
// (position is 0 when not found).
// A write item is taken in the idle state, which stays ready for the next
// item. A search item issues the first table read at its acceptance edge
// and then one read per probe, at most five probes for 16 entries, until
// the result register is loaded; only then does the block return to idle
// and accept the next item.
// After reset the table is swept to zero entry by entry, during which no
// item is accepted. If the receiver stalls, the result waits in the output
// register; the next item is still accepted, and a following search holds
// its result internally until the output register frees.
module sorted_table_binary_search (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stbs_in_if.sink      i_cmd,
    stbs_out_if.source   o_res
);

    stbs_pkg::t_dp_cmd    w_cmd;
    stbs_pkg::t_dp_status w_status;

    stbs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_cmd.valid),
        .i_in_command (i_cmd.command),
        .o_in_ready   (i_cmd.ready),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    stbs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_entry_index (i_cmd.entry_index),
        .i_entry_value (i_cmd.entry_value),
        .i_search_key  (i_cmd.search_key),
        .o_found       (o_res.found),
        .o_position    (o_res.position)
    );

endmodule
